### hw/rtl/two_agent_q_learning_step_defines.svh
// ---------------------------------------------------------------------------
// Two-agent Q-learning step: assertion macros
// Concurrent assertion wrappers that compile away in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef TWO_AGENT_Q_LEARNING_STEP_DEFINES_SVH
`define TWO_AGENT_Q_LEARNING_STEP_DEFINES_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define TQLS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tqls assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TQLS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tqls assertion failed");

`else

`define TQLS_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define TQLS_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/tqls_pkg.sv
// ---------------------------------------------------------------------------
// Two-agent Q-learning step: shared package
// Field widths, item codes, register indexes, reset values and the
// logistic lookup table used by the action choice.
// ---------------------------------------------------------------------------
package tqls_pkg;

  // Fixed field widths.
  localparam int PAY_W      = 24;  // payoffs, signed Q11.12
  localparam int PROB_W     = 16;  // probabilities, fraction of 65536
  localparam int CTRL_W     = 16;  // alpha, gamma, inverse temperature
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Fraction bits of alpha and gamma.
  localparam int FRAC_SH = 16;

  // Logistic table geometry: 16 segments of 2^23 over an argument in Q.24.
  localparam int SIG_STEP_BITS = 23;
  localparam int SIG_SEG_BITS  = 4;
  localparam int SIG_X_BITS    = SIG_STEP_BITS + SIG_SEG_BITS;
  localparam int SPAN_W        = 14;

  localparam logic [PROB_W-1:0] SIG_TOP  = 16'd65514;
  localparam logic [PROB_W:0]   PROB_ONE = 17'h10000;

  // Input item kinds.
  localparam logic KIND_PLAY    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEARN_RATE = 3'd0,
    REG_DISCOUNT   = 3'd1,
    REG_INV_TEMP   = 3'd2,
    REG_BENEFIT    = 3'd3,
    REG_COST       = 3'd4,
    REG_PENALTY    = 3'd5
  } cfg_reg_t;

  // Register reset values.
  localparam logic [CTRL_W-1:0]       LEARN_RATE_RST = 16'd6554;
  localparam logic [CTRL_W-1:0]       DISCOUNT_RST   = 16'd64881;
  localparam logic [CTRL_W-1:0]       INV_TEMP_RST   = 16'd12288;
  localparam logic signed [PAY_W-1:0] BENEFIT_RST    = 24'sd8192;
  localparam logic signed [PAY_W-1:0] COST_RST       = 24'sd4096;
  localparam logic signed [PAY_W-1:0] PENALTY_RST    = -24'sd4096;

  // Logistic samples at steps of 0.5 from 0 to 8.
  function automatic logic [PROB_W-1:0] sig_tab(input logic [SIG_SEG_BITS:0] idx);
    logic [PROB_W-1:0] val;
    unique case (idx)
      5'd0:    val = 16'd32768;
      5'd1:    val = 16'd40793;
      5'd2:    val = 16'd47911;
      5'd3:    val = 16'd53581;
      5'd4:    val = 16'd57724;
      5'd5:    val = 16'd60565;
      5'd6:    val = 16'd62428;
      5'd7:    val = 16'd63615;
      5'd8:    val = 16'd64357;
      5'd9:    val = 16'd64816;
      5'd10:   val = 16'd65097;
      5'd11:   val = 16'd65269;
      5'd12:   val = 16'd65374;
      5'd13:   val = 16'd65438;
      5'd14:   val = 16'd65476;
      5'd15:   val = 16'd65500;
      default: val = SIG_TOP;
    endcase
    return val;
  endfunction

  // Rise of the logistic over one segment.
  function automatic logic [SPAN_W-1:0] sig_span(input logic [SIG_SEG_BITS-1:0] seg);
    logic [PROB_W-1:0] lo;
    logic [PROB_W-1:0] hi;
    lo = sig_tab({1'b0, seg});
    hi = sig_tab({1'b0, seg} + 5'd1);
    return SPAN_W'(hi - lo);
  endfunction

  // Saturate a 25-bit payoff sum to the signed 24-bit range.
  function automatic logic signed [PAY_W-1:0] sat24(input logic signed [PAY_W:0] v);
    logic signed [PAY_W-1:0] res;
    if (v > 25'sd8388607) begin
      res = 24'sh7FFFFF;
    end else if (v < -25'sd8388608) begin
      res = 24'sh800000;
    end else begin
      res = v[PAY_W-1:0];
    end
    return res;
  endfunction

endpackage

### hw/rtl/tqls_in_if.sv
// ---------------------------------------------------------------------------
// Two-agent Q-learning step: input channel
// Carries play and restart items with their random fractions.
// ---------------------------------------------------------------------------
interface tqls_in_if #(
  parameter int RAND_WIDTH = 16
);
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [RAND_WIDTH-1:0] random_first;
  logic [RAND_WIDTH-1:0] random_second;
  logic                  start_state;

  modport source (
    output valid, kind, random_first, random_second, start_state,
    input  ready
  );

  modport sink (
    input  valid, kind, random_first, random_second, start_state,
    output ready
  );
endinterface

### hw/rtl/tqls_out_if.sv
// ---------------------------------------------------------------------------
// Two-agent Q-learning step: result channel
// Carries the actions, payoffs and cooperate probabilities of one round.
// ---------------------------------------------------------------------------
interface tqls_out_if;
  logic                                valid;
  logic                                ready;
  logic                                action_first;
  logic                                action_second;
  logic                                both_cooperated;
  logic                                next_state;
  logic signed [tqls_pkg::PAY_W-1:0]   reward_first;
  logic signed [tqls_pkg::PAY_W-1:0]   reward_second;
  logic        [tqls_pkg::PROB_W-1:0]  coop_prob_first_s0;
  logic        [tqls_pkg::PROB_W-1:0]  coop_prob_first_s1;
  logic        [tqls_pkg::PROB_W-1:0]  coop_prob_second_s0;
  logic        [tqls_pkg::PROB_W-1:0]  coop_prob_second_s1;

  modport source (
    output valid, action_first, action_second, both_cooperated, next_state,
           reward_first, reward_second, coop_prob_first_s0, coop_prob_first_s1,
           coop_prob_second_s0, coop_prob_second_s1,
    input  ready
  );

  modport sink (
    input  valid, action_first, action_second, both_cooperated, next_state,
           reward_first, reward_second, coop_prob_first_s0, coop_prob_first_s1,
           coop_prob_second_s0, coop_prob_second_s1,
    output ready
  );
endinterface

### hw/rtl/tqls_cfg_if.sv
// ---------------------------------------------------------------------------
// Two-agent Q-learning step: configuration write channel
// Carries a register index and its write data.
// ---------------------------------------------------------------------------
interface tqls_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tqls_pkg::CFG_IDX_W-1:0]      index;
  logic [tqls_pkg::CFG_DATA_W-1:0]     data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

### hw/rtl/two_agent_q_learning_step.sv
// ---------------------------------------------------------------------------
// Two-agent Q-learning step
// Q table for two agents, two game states and two actions. A play item
// picks both actions by a logistic choice, pays out, moves the game state
// and applies a saturating Q update; a restart item clears the table.
//
//   channel   direction  handshake      payload
//   in_ch     in         valid/ready    kind, random_first/second, start_state
//   out_ch    out        valid/ready    actions, next state, rewards, probs
//   cfg_ch    in         valid/ready    index, data (always ready)
//
// A play item runs through the probability, decision and update steps, and
// the block accepts the next item once it is back in idle; a restart item is
// handled within idle. One multiplier, shared by the probability, discount
// and learning-rate products, is used at most once per sequencer step.
// Reset restores the configuration defaults and marks the table empty.
// A result waiting on out_ch does not stop the next item from starting; the
// final step waits only when the previous result has not been taken yet.
// ---------------------------------------------------------------------------
`include "two_agent_q_learning_step_defines.svh"

module two_agent_q_learning_step #(
  parameter int Q_WIDTH    = 24,
  parameter int RAND_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  tqls_in_if.sink    in_ch,
  tqls_out_if.source out_ch,
  tqls_cfg_if.sink   cfg_ch
);

  // Error term width, multiplier operand and product widths.
  localparam int EW = ((Q_WIDTH > tqls_pkg::PAY_W) ? Q_WIDTH : tqls_pkg::PAY_W) + 2;
  localparam int MA = (EW > tqls_pkg::SIG_X_BITS + 1) ? EW : tqls_pkg::SIG_X_BITS + 1;
  localparam int MB = tqls_pkg::CTRL_W + 1;
  localparam int PW = MA + MB;
  localparam int SW = EW + 1;
  localparam int MW = (Q_WIDTH + 1 > tqls_pkg::SIG_X_BITS + 1) ?
                      Q_WIDTH + 1 : tqls_pkg::SIG_X_BITS + 1;

  localparam logic signed [SW-1:0] QMAX_S = {{(SW-Q_WIDTH+1){1'b0}}, {(Q_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] QMIN_S = {{(SW-Q_WIDTH+1){1'b1}}, {(Q_WIDTH-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PX,
    ST_PI,
    ST_PW,
    ST_DECIDE,
    ST_U0,
    ST_U1,
    ST_U2,
    ST_U3,
    ST_U4,
    ST_U5
  } state_t;

  state_t state_r;
  logic [1:0] k_r;

  // Configuration registers.
  logic        [tqls_pkg::CTRL_W-1:0] learn_rate_r;
  logic        [tqls_pkg::CTRL_W-1:0] discount_r;
  logic        [tqls_pkg::CTRL_W-1:0] inv_temp_r;
  logic signed [tqls_pkg::PAY_W-1:0]  benefit_r;
  logic signed [tqls_pkg::PAY_W-1:0]  cost_r;
  logic signed [tqls_pkg::PAY_W-1:0]  penalty_r;

  // Q table: entry index is agent, state, action.
  logic signed [Q_WIDTH-1:0] q_mem [8];
  logic [7:0]                q_valid_r;
  logic signed [Q_WIDTH-1:0] rd0_r;
  logic signed [Q_WIDTH-1:0] rd1_r;
  logic [1:0]                rd_row;
  logic                      q_we;
  logic [2:0]                q_waddr;
  logic signed [Q_WIDTH-1:0] q_wdata;

  // Shared multiplier.
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] mul_r;
  logic signed [EW-1:0] mul_hi;

  // Probability datapath.
  logic signed [MW-1:0]                 diff;
  logic        [MW-1:0]                 mag;
  logic                                 sat_c;
  logic                                 top_c;
  logic                                 neg_r;
  logic                                 sat_r;
  logic                                 top_r;
  logic [tqls_pkg::SIG_SEG_BITS-1:0]    i_r;
  logic [tqls_pkg::PROB_W:0]            p_lin;
  logic [tqls_pkg::PROB_W:0]            p_abs;
  logic [tqls_pkg::PROB_W:0]            p_sgn;
  logic [tqls_pkg::PROB_W-1:0]          prob_w;
  logic [tqls_pkg::PROB_W-1:0]          prob_r [4];

  // Round decision.
  logic [RAND_WIDTH-1:0]              rnd0_r;
  logic [RAND_WIDTH-1:0]              rnd1_r;
  logic                               game_state_r;
  logic [tqls_pkg::PROB_W-1:0]        p0_c;
  logic [tqls_pkg::PROB_W-1:0]        p1_c;
  logic                               act0_c;
  logic                               act1_c;
  logic                               nxt_c;
  logic signed [tqls_pkg::PAY_W-1:0]  bmc_c;
  logic signed [tqls_pkg::PAY_W-1:0]  negc_c;
  logic signed [tqls_pkg::PAY_W-1:0]  rew0_c;
  logic signed [tqls_pkg::PAY_W-1:0]  rew1_c;
  logic                               act0_r;
  logic                               act1_r;
  logic                               nxt_r;
  logic signed [tqls_pkg::PAY_W-1:0]  rew0_r;
  logic signed [tqls_pkg::PAY_W-1:0]  rew1_r;

  // Update datapath.
  logic signed [Q_WIDTH-1:0] qmax;
  logic signed [Q_WIDTH-1:0] cur_c;
  logic signed [EW-1:0]      gq_sel;
  logic signed [tqls_pkg::PAY_W-1:0] rew_sel;
  logic signed [EW-1:0]      e_c;
  logic signed [EW-1:0]      gq0_r;
  logic signed [EW-1:0]      gq1_r;
  logic signed [EW-1:0]      e0_r;
  logic signed [EW-1:0]      e1_r;
  logic signed [Q_WIDTH-1:0] cur0_r;
  logic signed [Q_WIDTH-1:0] cur1_r;
  logic signed [Q_WIDTH-1:0] wcur;
  logic signed [SW-1:0]      wsum;

  // Result register.
  logic                               out_valid_r;
  logic                               out_free;
  logic                               out_act0_r;
  logic                               out_act1_r;
  logic                               out_nxt_r;
  logic signed [tqls_pkg::PAY_W-1:0]  out_rew0_r;
  logic signed [tqls_pkg::PAY_W-1:0]  out_rew1_r;
  logic [tqls_pkg::PROB_W-1:0]        out_p00_r;
  logic [tqls_pkg::PROB_W-1:0]        out_p01_r;
  logic [tqls_pkg::PROB_W-1:0]        out_p10_r;
  logic [tqls_pkg::PROB_W-1:0]        out_p11_r;

  logic in_acc;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  // Table row to read in the next cycle, one step ahead of its use.
  // While idle the first row is read so a new item starts with it.
  always_comb begin
    rd_row = 2'd0;
    unique case (state_r)
      ST_IDLE:   rd_row = 2'd0;
      ST_PI:     rd_row = k_r + 2'd1;
      ST_DECIDE: rd_row = {1'b0, nxt_c};
      ST_U0:     rd_row = {1'b1, nxt_r};
      ST_U1:     rd_row = {1'b0, game_state_r};
      ST_U2:     rd_row = {1'b1, game_state_r};
      default:   rd_row = k_r;
    endcase
  end

  // Table write and registered read; entries never written read as zero.
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    rd0_r <= q_valid_r[{rd_row, 1'b0}] ? q_mem[{rd_row, 1'b0}] : '0;
    rd1_r <= q_valid_r[{rd_row, 1'b1}] ? q_mem[{rd_row, 1'b1}] : '0;
  end

  // Magnitude of Q0 - Q1 for the logistic argument.
  always_comb begin
    diff  = MW'(rd0_r) - MW'(rd1_r);
    mag   = diff[MW-1] ? MW'(-diff) : MW'(diff);
    sat_c = |mag[MW-1:tqls_pkg::SIG_X_BITS];
    top_c = sat_r || (|mul_r[PW-1:tqls_pkg::SIG_X_BITS]);
  end

  // Interpolated logistic and its mirror for a negative argument.
  always_comb begin
    p_lin = (tqls_pkg::PROB_W+1)'(tqls_pkg::sig_tab({1'b0, i_r}))
          + (tqls_pkg::PROB_W+1)'(mul_r[tqls_pkg::SIG_STEP_BITS+tqls_pkg::SPAN_W-1:
                                        tqls_pkg::SIG_STEP_BITS]);
    p_abs  = top_r ? {1'b0, tqls_pkg::SIG_TOP} : p_lin;
    p_sgn  = neg_r ? (tqls_pkg::PROB_ONE - p_abs) : p_abs;
    prob_w = p_sgn[tqls_pkg::PROB_W-1:0];
  end

  // Action choice, next state and payoffs.
  always_comb begin
    p0_c   = game_state_r ? prob_r[1] : prob_r[0];
    p1_c   = game_state_r ? prob_r[3] : prob_r[2];
    act0_c = !({rnd0_r, {tqls_pkg::PROB_W{1'b0}}} < {p0_c, {RAND_WIDTH{1'b0}}});
    act1_c = !({rnd1_r, {tqls_pkg::PROB_W{1'b0}}} < {p1_c, {RAND_WIDTH{1'b0}}});
    nxt_c  = act0_c || act1_c;
    bmc_c  = tqls_pkg::sat24((tqls_pkg::PAY_W+1)'(benefit_r) -
                             (tqls_pkg::PAY_W+1)'(cost_r));
    negc_c = tqls_pkg::sat24(-(tqls_pkg::PAY_W+1)'(cost_r));
    if (game_state_r) begin
      rew0_c = penalty_r;
      rew1_c = penalty_r;
    end else begin
      unique case ({act0_c, act1_c})
        2'b00: begin
          rew0_c = bmc_c;
          rew1_c = bmc_c;
        end
        2'b01: begin
          rew0_c = negc_c;
          rew1_c = benefit_r;
        end
        2'b10: begin
          rew0_c = benefit_r;
          rew1_c = negc_c;
        end
        default: begin
          rew0_c = '0;
          rew1_c = '0;
        end
      endcase
    end
  end

  // Update terms: max over the next state, error, saturated new entry.
  always_comb begin
    mul_hi  = mul_r[EW+tqls_pkg::FRAC_SH-1:tqls_pkg::FRAC_SH];
    qmax    = (rd0_r > rd1_r) ? rd0_r : rd1_r;
    if (state_r == ST_U2) begin
      cur_c   = act0_r ? rd1_r : rd0_r;
      gq_sel  = gq0_r;
      rew_sel = rew0_r;
    end else begin
      cur_c   = act1_r ? rd1_r : rd0_r;
      gq_sel  = gq1_r;
      rew_sel = rew1_r;
    end
    e_c     = EW'(rew_sel) + gq_sel - EW'(cur_c);
    wcur    = (state_r == ST_U4) ? cur0_r : cur1_r;
    wsum    = SW'(wcur) + SW'(mul_hi);
    if (wsum > QMAX_S) begin
      q_wdata = QMAX_S[Q_WIDTH-1:0];
    end else if (wsum < QMIN_S) begin
      q_wdata = QMIN_S[Q_WIDTH-1:0];
    end else begin
      q_wdata = wsum[Q_WIDTH-1:0];
    end
    q_we    = (state_r == ST_U4) || ((state_r == ST_U5) && out_free);
    q_waddr = (state_r == ST_U4) ? {1'b0, game_state_r, act0_r}
                                 : {1'b1, game_state_r, act1_r};
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_PX: begin
        mul_a = MA'($signed({1'b0, mag[tqls_pkg::SIG_X_BITS-1:0]}));
        mul_b = $signed({1'b0, inv_temp_r});
      end
      ST_PI: begin
        mul_a = MA'($signed({1'b0, mul_r[tqls_pkg::SIG_STEP_BITS-1:0]}));
        mul_b = $signed(MB'(tqls_pkg::sig_span(
                  mul_r[tqls_pkg::SIG_X_BITS-1:tqls_pkg::SIG_STEP_BITS])));
      end
      ST_U0, ST_U1: begin
        mul_a = MA'(qmax);
        mul_b = $signed({1'b0, discount_r});
      end
      ST_U3: begin
        mul_a = MA'(e0_r);
        mul_b = $signed({1'b0, learn_rate_r});
      end
      ST_U4, ST_U5: begin
        mul_a = MA'(e1_r);
        mul_b = $signed({1'b0, learn_rate_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  // Sequencer, configuration registers and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      k_r          <= 2'd0;
      q_valid_r    <= '0;
      game_state_r <= 1'b0;
      out_valid_r  <= 1'b0;
      learn_rate_r <= tqls_pkg::LEARN_RATE_RST;
      discount_r   <= tqls_pkg::DISCOUNT_RST;
      inv_temp_r   <= tqls_pkg::INV_TEMP_RST;
      benefit_r    <= tqls_pkg::BENEFIT_RST;
      cost_r       <= tqls_pkg::COST_RST;
      penalty_r    <= tqls_pkg::PENALTY_RST;
    end else begin
      // Register writes.
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          tqls_pkg::REG_LEARN_RATE: learn_rate_r <= cfg_ch.data[tqls_pkg::CTRL_W-1:0];
          tqls_pkg::REG_DISCOUNT:   discount_r   <= cfg_ch.data[tqls_pkg::CTRL_W-1:0];
          tqls_pkg::REG_INV_TEMP:   inv_temp_r   <= cfg_ch.data[tqls_pkg::CTRL_W-1:0];
          tqls_pkg::REG_BENEFIT:    benefit_r    <= cfg_ch.data;
          tqls_pkg::REG_COST:       cost_r       <= cfg_ch.data;
          tqls_pkg::REG_PENALTY:    penalty_r    <= cfg_ch.data;
          default: ;
        endcase
      end

      // A taken result frees the register unless the final step reloads it.
      if (out_valid_r && out_ch.ready && (state_r != ST_U5)) begin
        out_valid_r <= 1'b0;
      end

      if (q_we) begin
        q_valid_r[q_waddr] <= 1'b1;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_ch.kind == tqls_pkg::KIND_RESTART) begin
              q_valid_r    <= '0;
              game_state_r <= in_ch.start_state;
            end else begin
              rnd0_r  <= in_ch.random_first;
              rnd1_r  <= in_ch.random_second;
              k_r     <= 2'd0;
              state_r <= ST_PX;
            end
          end
        end
        // Argument product for row k; finish the previous row's probability.
        ST_PX: begin
          neg_r <= diff[MW-1];
          sat_r <= sat_c && (inv_temp_r != '0);
          if (k_r != 2'd0) begin
            prob_r[k_r - 2'd1] <= prob_w;
          end
          state_r <= ST_PI;
        end
        // Segment lookup and interpolation product.
        ST_PI: begin
          top_r <= top_c;
          i_r   <= mul_r[tqls_pkg::SIG_X_BITS-1:tqls_pkg::SIG_STEP_BITS];
          if (k_r == 2'd3) begin
            state_r <= ST_PW;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= ST_PX;
          end
        end
        ST_PW: begin
          prob_r[3] <= prob_w;
          state_r   <= ST_DECIDE;
        end
        ST_DECIDE: begin
          act0_r  <= act0_c;
          act1_r  <= act1_c;
          nxt_r   <= nxt_c;
          rew0_r  <= rew0_c;
          rew1_r  <= rew1_c;
          state_r <= ST_U0;
        end
        ST_U0: begin
          state_r <= ST_U1;
        end
        ST_U1: begin
          gq0_r   <= mul_hi;
          state_r <= ST_U2;
        end
        ST_U2: begin
          gq1_r   <= mul_hi;
          cur0_r  <= cur_c;
          e0_r    <= e_c;
          state_r <= ST_U3;
        end
        ST_U3: begin
          cur1_r  <= cur_c;
          e1_r    <= e_c;
          state_r <= ST_U4;
        end
        ST_U4: begin
          state_r <= ST_U5;
        end
        // Second entry written as the result is loaded.
        ST_U5: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_act0_r   <= act0_r;
            out_act1_r   <= act1_r;
            out_nxt_r    <= nxt_r;
            out_rew0_r   <= rew0_r;
            out_rew1_r   <= rew1_r;
            out_p00_r    <= prob_r[0];
            out_p01_r    <= prob_r[1];
            out_p10_r    <= prob_r[2];
            out_p11_r    <= prob_r[3];
            game_state_r <= nxt_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Result channel.
  assign out_ch.valid               = out_valid_r;
  assign out_ch.action_first        = out_act0_r;
  assign out_ch.action_second       = out_act1_r;
  assign out_ch.both_cooperated     = !out_nxt_r;
  assign out_ch.next_state          = out_nxt_r;
  assign out_ch.reward_first        = out_rew0_r;
  assign out_ch.reward_second       = out_rew1_r;
  assign out_ch.coop_prob_first_s0  = out_p00_r;
  assign out_ch.coop_prob_first_s1  = out_p01_r;
  assign out_ch.coop_prob_second_s0 = out_p10_r;
  assign out_ch.coop_prob_second_s1 = out_p11_r;

  // A restart leaves the whole table empty.
  `TQLS_ASSERT_NEXT(a_restart_clears, clk, rst_n, in_acc && (in_ch.kind == tqls_pkg::KIND_RESTART), q_valid_r == '0)
  // Table writes happen only in the two update steps.
  `TQLS_ASSERT_NOW(a_write_in_update, clk, rst_n, q_we, (state_r == ST_U4) || (state_r == ST_U5))
  // A new result appears only out of the final update step.
  `TQLS_ASSERT_NOW(a_out_from_last, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_U5)
  // Both agents cooperating and the next state agree.
  `TQLS_ASSERT_NOW(a_out_consistent, clk, rst_n, out_ch.valid, out_ch.both_cooperated != out_ch.next_state)

endmodule
